// ----- design/lsra_pkg.sv -----
package lsra_pkg;

   localparam int ID_WIDTH = 16;
   localparam int FIELD_POS_WIDTH = 16;
   localparam int REG_FIELD_WIDTH = 4;
   localparam int CFG_WIDTH = 5;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd16;

   typedef struct packed {
      logic load;
      logic expire;
      logic decide;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_blocked;
   } status_type;

endpackage

// ----- design/lsra_ctrl.sv -----
module lsra_ctrl
   import lsra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPIRE = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            cmd.expire = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register frees up
            if (!status.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/lsra_datapath.sv -----
module lsra_datapath
   import lsra_pkg::*;
#(
   parameter int MAX_REGS = 16,
   parameter int POS_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic                       csr_write_enable,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   input  logic                       req_start_of_function,
   input  logic [ID_WIDTH-1:0]        req_value_id,
   input  logic [FIELD_POS_WIDTH-1:0] req_interval_start,
   input  logic [FIELD_POS_WIDTH-1:0] req_interval_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ID_WIDTH-1:0]        rsp_result_value_id,
   output logic                       rsp_spilled,
   output logic [REG_FIELD_WIDTH-1:0] rsp_assigned_register,
   output logic                       rsp_evicted_valid,
   output logic [ID_WIDTH-1:0]        rsp_evicted_value_id
);

   localparam int PW = (POS_BITS < FIELD_POS_WIDTH) ? POS_BITS : FIELD_POS_WIDTH;
   localparam int SW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
   localparam int CW = $clog2(MAX_REGS + 1);
   localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

   logic [CFG_WIDTH-1:0] reg_count_ff;

   logic [MAX_REGS-1:0] busy_ff, busy_in;
   logic [PW-1:0]       end_ff   [MAX_REGS];
   logic [PW-1:0]       end_in   [MAX_REGS];
   logic [ID_WIDTH-1:0] value_ff [MAX_REGS];
   logic [ID_WIDTH-1:0] value_in [MAX_REGS];
   logic [SW-1:0]       rank_ff  [MAX_REGS];
   logic [SW-1:0]       rank_in  [MAX_REGS];

   logic [ID_WIDTH-1:0] vid_ff;
   logic [PW-1:0]       start_ff;
   logic [PW-1:0]       new_end_ff;

   logic                dec_alloc_ff;
   logic                dec_evict_ff;
   logic [SW-1:0]       dec_slot_ff;
   logic [SW-1:0]       dec_rank_ff;
   logic [SW-1:0]       dec_victim_rank_ff;
   logic [ID_WIDTH-1:0] dec_victim_id_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0]        rsp_id_ff;
   logic                       rsp_spilled_ff;
   logic [REG_FIELD_WIDTH-1:0] rsp_reg_ff;
   logic                       rsp_ev_valid_ff;
   logic [ID_WIDTH-1:0]        rsp_ev_id_ff;

   logic [MAX_REGS-1:0] expired;
   logic [SW-1:0]       compact_rank [MAX_REGS];
   logic [CW-1:0]       busy_n;
   logic [LW-1:0]       limit;
   logic                alloc;
   logic [SW-1:0]       free_slot;
   logic [MAX_REGS-1:0] cand;
   logic [MAX_REGS-1:0] win;
   logic [SW-1:0]       win_slot;
   logic                found;

   // expiry and rank compaction
   always_comb begin
      for (int k = 0; k < MAX_REGS; k++) begin
         expired[k] = busy_ff[k] && (end_ff[k] < start_ff);
      end
      for (int k = 0; k < MAX_REGS; k++) begin
         compact_rank[k] = '0;
         for (int j = 0; j < MAX_REGS; j++) begin
            if (busy_ff[j] && !expired[j] && (rank_ff[j] < rank_ff[k])) begin
               compact_rank[k] = compact_rank[k] + SW'(1);
            end
         end
      end
   end

   // allocation or contest
   always_comb begin
      busy_n    = '0;
      free_slot = '0;
      for (int k = 0; k < MAX_REGS; k++) begin
         if (busy_ff[k]) begin
            busy_n = busy_n + CW'(1);
         end
      end
      for (int k = MAX_REGS - 1; k >= 0; k--) begin
         if (!busy_ff[k]) begin
            free_slot = SW'(k);
         end
      end
      limit = (LW'(reg_count_ff) > LW'(MAX_REGS)) ? LW'(MAX_REGS) : LW'(reg_count_ff);
      alloc = LW'(busy_n) < limit;
      for (int k = 0; k < MAX_REGS; k++) begin
         cand[k] = busy_ff[k] && (end_ff[k] > new_end_ff);
      end
      for (int k = 0; k < MAX_REGS; k++) begin
         win[k] = cand[k];
         for (int j = 0; j < MAX_REGS; j++) begin
            if (j != k && cand[j]) begin
               if (!((end_ff[k] > end_ff[j]) ||
                     ((end_ff[k] == end_ff[j]) && (rank_ff[k] < rank_ff[j])))) begin
                  win[k] = 1'b0;
               end
            end
         end
      end
      found    = |cand;
      win_slot = '0;
      for (int k = 0; k < MAX_REGS; k++) begin
         if (win[k]) begin
            win_slot = win_slot | SW'(k);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      for (int k = 0; k < MAX_REGS; k++) begin
         end_in[k]   = end_ff[k];
         value_in[k] = value_ff[k];
         rank_in[k]  = rank_ff[k];
      end
      if (cmd.load && req_start_of_function) begin
         busy_in = '0;
      end
      if (cmd.expire) begin
         for (int k = 0; k < MAX_REGS; k++) begin
            busy_in[k] = busy_ff[k] & ~expired[k];
            rank_in[k] = compact_rank[k];
         end
      end
      if (cmd.commit && (dec_alloc_ff || dec_evict_ff)) begin
         if (dec_evict_ff) begin
            for (int k = 0; k < MAX_REGS; k++) begin
               if (busy_ff[k] && (rank_ff[k] > dec_victim_rank_ff)) begin
                  rank_in[k] = rank_ff[k] - SW'(1);
               end
            end
         end
         busy_in[dec_slot_ff]  = 1'b1;
         end_in[dec_slot_ff]   = new_end_ff;
         value_in[dec_slot_ff] = vid_ff;
         rank_in[dec_slot_ff]  = dec_rank_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_count_ff <= CFG_RESET;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            reg_count_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_REGS; k++) begin
         end_ff[k]   <= end_in[k];
         value_ff[k] <= value_in[k];
         rank_ff[k]  <= rank_in[k];
      end
      if (cmd.load) begin
         vid_ff     <= req_value_id;
         start_ff   <= req_interval_start[PW-1:0];
         new_end_ff <= req_interval_end[PW-1:0];
      end
      if (cmd.decide) begin
         dec_alloc_ff       <= alloc;
         dec_evict_ff       <= !alloc && found;
         dec_slot_ff        <= alloc ? free_slot : win_slot;
         dec_rank_ff        <= alloc ? SW'(busy_n) : SW'(busy_n - CW'(1));
         dec_victim_rank_ff <= rank_ff[win_slot];
         dec_victim_id_ff   <= value_ff[win_slot];
      end
      if (cmd.commit) begin
         rsp_id_ff       <= vid_ff;
         rsp_spilled_ff  <= !(dec_alloc_ff || dec_evict_ff);
         rsp_reg_ff      <= (dec_alloc_ff || dec_evict_ff) ?
                            REG_FIELD_WIDTH'(dec_slot_ff) : '0;
         rsp_ev_valid_ff <= dec_evict_ff;
         rsp_ev_id_ff    <= dec_evict_ff ? dec_victim_id_ff : '0;
      end
   end

   assign status.out_blocked    = rsp_valid_ff && !rsp_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_value_id   = rsp_id_ff;
   assign rsp_spilled           = rsp_spilled_ff;
   assign rsp_assigned_register = rsp_reg_ff;
   assign rsp_evicted_valid     = rsp_ev_valid_ff;
   assign rsp_evicted_value_id  = rsp_ev_id_ff;

endmodule

// ----- design/linear_scan_register_allocator_unit.sv -----
// Channel   Handshake                Payload
// req       req_valid / req_ready    start_of_function, value_id, interval_start, interval_end
// rsp       rsp_valid / rsp_ready    result_value_id, spilled, assigned_register,
//                                    evicted_valid, evicted_value_id
// csr       csr_write_enable         csr_write_data (reg_count)
//
// Each interval passes through the steps accept, expire, decide and commit, run by the controller FSM.
// The commit step waits while the result register still holds an untaken transfer.
// Synchronous active-high reset empties the slot table and sets reg_count to 16.
// The result register lets the next interval be accepted while a result waits.
module linear_scan_register_allocator_unit
   import lsra_pkg::*;
#(
   parameter int MAX_REGS = 16,
   parameter int POS_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CFG_WIDTH-1:0]       csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_start_of_function,
   input  logic [ID_WIDTH-1:0]        req_value_id,
   input  logic [FIELD_POS_WIDTH-1:0] req_interval_start,
   input  logic [FIELD_POS_WIDTH-1:0] req_interval_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ID_WIDTH-1:0]        rsp_result_value_id,
   output logic                       rsp_spilled,
   output logic [REG_FIELD_WIDTH-1:0] rsp_assigned_register,
   output logic                       rsp_evicted_valid,
   output logic [ID_WIDTH-1:0]        rsp_evicted_value_id
);

   cmd_type    cmd;
   status_type status;

   lsra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsra_datapath #(
      .MAX_REGS (MAX_REGS),
      .POS_BITS (POS_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_start_of_function (req_start_of_function),
      .req_value_id          (req_value_id),
      .req_interval_start    (req_interval_start),
      .req_interval_end      (req_interval_end),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_value_id   (rsp_result_value_id),
      .rsp_spilled           (rsp_spilled),
      .rsp_assigned_register (rsp_assigned_register),
      .rsp_evicted_valid     (rsp_evicted_valid),
      .rsp_evicted_value_id  (rsp_evicted_value_id)
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.expire, cmd.decide, cmd.commit}))
      else $error("controller issued overlapping commands");

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again while an interval is in work");

   a_spill_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_spilled && rsp_evicted_valid))
      else $error("spilled result also reports an eviction");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && !rsp_ready))
      else $error("commit overwrote an untaken result");

endmodule

// ----- tb/tb.sv -----
module tb;
   import lsra_pkg::*;

   localparam int NUM_SLOTS     = 16;
   localparam int RANDOM_ITEMS  = 800;
   localparam int BLOCK_ITEMS   = 40;
   localparam int DRAIN_CYCLES  = 12;
   localparam int TIMEOUT_UNITS = 3_200_000;

   typedef struct packed {
      logic                       start_of_function;
      logic [ID_WIDTH-1:0]        ssa_id;
      logic [FIELD_POS_WIDTH-1:0] first_pos;
      logic [FIELD_POS_WIDTH-1:0] end_pos;
   } interval_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]        ssa_id;
      logic                       spilled;
      logic [REG_FIELD_WIDTH-1:0] assigned_register;
      logic                       evicted_valid;
      logic [ID_WIDTH-1:0]        evicted_value_id;
   } alloc_result_type;

   typedef struct packed {
      bit                   cfg_wr;
      logic [CFG_WIDTH-1:0] cfg_val;
      interval_type         item;
      bit                   typed;
      alloc_result_type     want;
   } dir_row_type;

   localparam alloc_result_type NO_RESULT = '0;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CFG_WIDTH-1:0]       csr_write_data;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_start_of_function;
   logic [ID_WIDTH-1:0]        req_value_id;
   logic [FIELD_POS_WIDTH-1:0] req_interval_start;
   logic [FIELD_POS_WIDTH-1:0] req_interval_end;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [ID_WIDTH-1:0]        rsp_result_value_id;
   logic                       rsp_spilled;
   logic [REG_FIELD_WIDTH-1:0] rsp_assigned_register;
   logic                       rsp_evicted_valid;
   logic [ID_WIDTH-1:0]        rsp_evicted_value_id;

   // allocator state as seen by the predictor
   logic                       slot_live  [NUM_SLOTS];
   logic [FIELD_POS_WIDTH-1:0] slot_last  [NUM_SLOTS];
   logic [ID_WIDTH-1:0]        slot_owner [NUM_SLOTS];
   int unsigned                slot_order [NUM_SLOTS];
   logic [CFG_WIDTH-1:0]       model_reg_count;

   alloc_result_type           pending_allocs[$];
   int                         mismatch_count = 0;
   int unsigned                req_idle_pct = 18;
   int unsigned                rsp_idle_pct = 56;
   int unsigned                hold_off_cycles = 0;
   int unsigned                fn_left = 0;
   logic [FIELD_POS_WIDTH-1:0] fn_pos = '0;

   dir_row_type directed [17] = '{
      '{1'b0, 5'd0,  '{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF},
        1'b1, '{16'hFFFF, 1'b0, 4'd0, 1'b0, 16'h0000}},
      '{1'b0, 5'd0,  '{1'b0, 16'h0000, 16'h0000, 16'h0000},
        1'b1, '{16'h0000, 1'b0, 4'd1, 1'b0, 16'h0000}},
      '{1'b0, 5'd0,  '{1'b0, 16'h1234, 16'h0001, 16'h0010}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h00AA, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b1, 5'd0,  '{1'b1, 16'h5555, 16'h0010, 16'h0020},
        1'b1, '{16'h5555, 1'b1, 4'd0, 1'b0, 16'h0000}},
      '{1'b1, 5'd2,  '{1'b1, 16'h0A01, 16'h000A, 16'h0064},
        1'b1, '{16'h0A01, 1'b0, 4'd0, 1'b0, 16'h0000}},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A02, 16'h000B, 16'h0064}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A03, 16'h000C, 16'h0032}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A04, 16'h000D, 16'h00C8}, 1'b0, NO_RESULT},
      '{1'b1, 5'd1,  '{1'b0, 16'h0A05, 16'h000E, 16'h003C}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A06, 16'h0014, 16'h0005}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A07, 16'h001E, 16'h0028}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0A08, 16'h0000, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b1, 5'd31, '{1'b1, 16'h7FFF, 16'h8000, 16'h8000},
        1'b1, '{16'h7FFF, 1'b0, 4'd0, 1'b0, 16'h0000}},
      '{1'b0, 5'd0,  '{1'b0, 16'h8000, 16'h8000, 16'h7FFF}, 1'b0, NO_RESULT},
      '{1'b0, 5'd0,  '{1'b0, 16'h0001, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b1, 5'd16, '{1'b1, 16'hC0DE, 16'h0100, 16'h0100},
        1'b1, '{16'hC0DE, 1'b0, 4'd0, 1'b0, 16'h0000}}
   };

   linear_scan_register_allocator_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_start_of_function (req_start_of_function),
      .req_value_id          (req_value_id),
      .req_interval_start    (req_interval_start),
      .req_interval_end      (req_interval_end),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_value_id   (rsp_result_value_id),
      .rsp_spilled           (rsp_spilled),
      .rsp_assigned_register (rsp_assigned_register),
      .rsp_evicted_valid     (rsp_evicted_valid),
      .rsp_evicted_value_id  (rsp_evicted_value_id)
   );

   always #4 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void clear_slots();
      int j;
      for (j = 0; j < NUM_SLOTS; j++) begin
         slot_live[j]  = 1'b0;
         slot_last[j]  = '0;
         slot_owner[j] = '0;
         slot_order[j] = 0;
      end
   endfunction

   function automatic void release_slot(input int s);
      int unsigned r;
      int j;
      r = slot_order[s];
      slot_live[s]  = 1'b0;
      slot_last[s]  = '0;
      slot_owner[s] = '0;
      slot_order[s] = 0;
      for (j = 0; j < NUM_SLOTS; j++)
         if (slot_live[j] && slot_order[j] > r)
            slot_order[j]--;
   endfunction

   function automatic int unsigned live_count();
      int unsigned n;
      int j;
      n = 0;
      for (j = 0; j < NUM_SLOTS; j++)
         if (slot_live[j])
            n++;
      return n;
   endfunction

   function automatic alloc_result_type allocate_interval(input interval_type it);
      alloc_result_type res;
      int unsigned      limit;
      int unsigned      busy;
      int               j;
      int               pick;
      bit               found;
      res = '0;
      res.ssa_id = it.ssa_id;
      limit = (model_reg_count > NUM_SLOTS) ? NUM_SLOTS : model_reg_count;
      if (it.start_of_function)
         clear_slots();
      for (j = 0; j < NUM_SLOTS; j++)
         if (slot_live[j] && slot_last[j] < it.first_pos)
            release_slot(j);
      busy = live_count();
      pick = -1;
      if (busy < limit) begin
         for (j = NUM_SLOTS - 1; j >= 0; j--)
            if (!slot_live[j])
               pick = j;
      end else begin
         found = 1'b0;
         for (j = 0; j < NUM_SLOTS; j++) begin
            if (slot_live[j] && slot_last[j] > it.end_pos) begin
               if (!found || slot_last[j] > slot_last[pick] ||
                   (slot_last[j] == slot_last[pick] && slot_order[j] < slot_order[pick])) begin
                  pick  = j;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            res.evicted_valid    = 1'b1;
            res.evicted_value_id = slot_owner[pick];
            release_slot(pick);
            busy = live_count();
         end
      end
      if (pick < 0) begin
         res.spilled = 1'b1;
      end else begin
         slot_live[pick]  = 1'b1;
         slot_last[pick]  = it.end_pos;
         slot_owner[pick] = it.ssa_id;
         slot_order[pick] = busy;
         res.assigned_register = pick[REG_FIELD_WIDTH-1:0];
      end
      return res;
   endfunction

   function automatic logic [CFG_WIDTH-1:0] pick_reg_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 5'd0;
      if (r < 16) return 5'd16;
      if (r < 22) return 5'd31;
      if (r < 30) return CFG_WIDTH'($urandom_range(17, 30));
      if (r < 45) return CFG_WIDTH'($urandom_range(5, 15));
      return CFG_WIDTH'($urandom_range(1, 4));
   endfunction

   // mostly well-formed functions: ascending starts, short overlapping lives
   function automatic interval_type next_interval();
      interval_type it;
      int unsigned  r;
      it.ssa_id = ID_WIDTH'($urandom_range(0, 65535));
      it.start_of_function = 1'b0;
      if (fn_left == 0) begin
         it.start_of_function = 1'b1;
         fn_pos  = FIELD_POS_WIDTH'($urandom_range(0, 65535));
         fn_left = $urandom_range(4, 40);
      end else if ($urandom_range(0, 99) < 3) begin
         it.start_of_function = 1'b1;
      end
      fn_left--;
      fn_pos = fn_pos + FIELD_POS_WIDTH'($urandom_range(0, 3));
      it.first_pos = fn_pos;
      if ($urandom_range(0, 99) < 4)
         it.first_pos = FIELD_POS_WIDTH'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 78)
         it.end_pos = it.first_pos + FIELD_POS_WIDTH'($urandom_range(0, 30));
      else if (r < 86)
         it.end_pos = FIELD_POS_WIDTH'($urandom_range(0, 65535));
      else if (r < 93)
         it.end_pos = it.first_pos - FIELD_POS_WIDTH'($urandom_range(1, 20));
      else
         it.end_pos = '1;
      return it;
   endfunction

   task automatic send_interval(input interval_type it, input bit typed,
                                input alloc_result_type typed_want);
      alloc_result_type got;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_start_of_function <= it.start_of_function;
      req_value_id          <= it.ssa_id;
      req_interval_start    <= it.first_pos;
      req_interval_end      <= it.end_pos;
      do @(posedge clock); while (req_ready !== 1'b1);
      got = allocate_interval(it);
      pending_allocs.insert(pending_allocs.size(), typed ? typed_want : got);
   endtask

   task automatic write_reg_count(input logic [CFG_WIDTH-1:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_allocs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      model_reg_count = val;
   endtask

   // result side: random stalls plus the occasional long hold
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_allocs.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer, value id %h", rsp_result_value_id));
         end else begin
            want = pending_allocs.pop_front();
            if (rsp_result_value_id !== want.ssa_id)
               flag_mismatch($sformatf("value id %h, want %h",
                                       rsp_result_value_id, want.ssa_id));
            if (rsp_spilled !== want.spilled)
               flag_mismatch($sformatf("id %h: spilled %b, want %b",
                                       want.ssa_id, rsp_spilled, want.spilled));
            if (rsp_assigned_register !== want.assigned_register)
               flag_mismatch($sformatf("id %h: register %0d, want %0d", want.ssa_id,
                                       rsp_assigned_register, want.assigned_register));
            if (rsp_evicted_valid !== want.evicted_valid)
               flag_mismatch($sformatf("id %h: evicted_valid %b, want %b", want.ssa_id,
                                       rsp_evicted_valid, want.evicted_valid));
            if (rsp_evicted_value_id !== want.evicted_value_id)
               flag_mismatch($sformatf("id %h: evicted id %h, want %h", want.ssa_id,
                                       rsp_evicted_value_id, want.evicted_value_id));
         end
      end
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int phase;
      int n;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_valid             = 1'b0;
      req_start_of_function = 1'b0;
      req_value_id          = '0;
      req_interval_start    = '0;
      req_interval_end      = '0;
      model_reg_count       = CFG_RESET;
      clear_slots();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].cfg_wr)
            write_reg_count(directed[i].cfg_val);
         send_interval(directed[i].item, directed[i].typed, directed[i].want);
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 18;
               rsp_idle_pct = 56;
            end
            1: begin
               req_idle_pct = 56;
               rsp_idle_pct = 18;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (n % BLOCK_ITEMS == 0)
               write_reg_count(pick_reg_count());
            // hold the result side while requests keep coming
            if (n == 100)
               hold_off_cycles = $urandom_range(60, 120);
            send_interval(next_interval(), 1'b0, NO_RESULT);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_allocs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lsra_pkg.sv
design/lsra_ctrl.sv
design/lsra_datapath.sv
design/linear_scan_register_allocator_unit.sv
tb/tb.sv
